// ===== design/pce_pkg.sv =====
// pce_pkg: opcodes, flag positions and shared structs for the execute block
// no dependencies
`default_nettype none

package pce_pkg;

    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_DEC_B   = 8'h05;
    localparam logic [7:0] OP_LD_B    = 8'h06;
    localparam logic [7:0] OP_DEC_C   = 8'h0D;
    localparam logic [7:0] OP_LD_C    = 8'h0E;
    localparam logic [7:0] OP_LD_D    = 8'h16;
    localparam logic [7:0] OP_LD_E    = 8'h1E;
    localparam logic [7:0] OP_JR_NZ   = 8'h20;
    localparam logic [7:0] OP_LD_HL16 = 8'h21;
    localparam logic [7:0] OP_LD_HLI  = 8'h22;
    localparam logic [7:0] OP_LD_H    = 8'h26;
    localparam logic [7:0] OP_LD_L    = 8'h2E;
    localparam logic [7:0] OP_LD_HLD  = 8'h32;
    localparam logic [7:0] OP_JR_C    = 8'h38;
    localparam logic [7:0] OP_LD_A    = 8'h3E;
    localparam logic [7:0] OP_XOR_A   = 8'hAF;
    localparam logic [7:0] OP_JP      = 8'hC3;
    localparam logic [7:0] OP_LDH_ST  = 8'hE0;
    localparam logic [7:0] OP_LDH_LD  = 8'hF0;
    localparam logic [7:0] OP_DI      = 8'hF3;
    localparam logic [7:0] OP_CP      = 8'hFE;

    localparam int FLAG_Z = 7;
    localparam int FLAG_N = 6;
    localparam int FLAG_H = 5;
    localparam int FLAG_C = 4;

    localparam logic [7:0] HIGH_PAGE = 8'hFF;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  f;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] pc;
    } t_state;

    typedef struct packed {
        logic [7:0] mode;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] read_data;
    } t_item;

    typedef struct packed {
        logic        mem_write;
        logic        mem_read;
        logic [15:0] mem_address;
        logic [7:0]  write_data;
        logic [15:0] next_pc;
        logic [2:0]  machine_cycles;
        logic        unimplemented;
    } t_result;

endpackage

`default_nettype wire

// ===== design/pce_if.sv =====
// pce_req_if / pce_res_if: valid-ready channels for instruction requests and results
// no dependencies
`default_nettype none

interface pce_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] mode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] read_data;

    modport source (output valid, mode, imm_low, imm_high, read_data, input ready);
    modport sink   (input valid, mode, imm_low, imm_high, read_data, output ready);
endinterface

interface pce_res_if;
    logic        valid;
    logic        ready;
    logic        mem_write;
    logic        mem_read;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic [15:0] next_pc;
    logic [2:0]  machine_cycles;
    logic        unimplemented;

    modport source (output valid, mem_write, mem_read, mem_address, write_data, next_pc,
                    machine_cycles, unimplemented, input ready);
    modport sink   (input valid, mem_write, mem_read, mem_address, write_data, next_pc,
                    machine_cycles, unimplemented, output ready);
endinterface

`default_nettype wire

// ===== design/pce_exec.sv =====
// pce_exec: single-pass decode and execute of one instruction against the register state
// depends on pce_pkg
`default_nettype none

module pce_exec
    import pce_pkg::*;
(
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    logic [15:0] pc_p1;
    logic [15:0] pc_p2;
    logic [15:0] pc_p3;
    logic [15:0] hl;
    logic [7:0]  dec_b;
    logic [7:0]  dec_c;
    logic [7:0]  f_dec_b;
    logic [7:0]  f_dec_c;
    logic [7:0]  f_cp;
    logic        jr_taken;
    logic [15:0] jr_target;

    always_comb begin
        pc_p1     = i_state.pc + 16'd1;
        pc_p2     = i_state.pc + 16'd2;
        pc_p3     = i_state.pc + 16'd3;
        hl        = {i_state.h, i_state.l};
        dec_b     = i_state.b - 8'd1;
        dec_c     = i_state.c - 8'd1;
        f_dec_b   = {dec_b == 8'd0, 1'b1, dec_b[3:0] == 4'hF, i_state.f[FLAG_C], 4'h0};
        f_dec_c   = {dec_c == 8'd0, 1'b1, dec_c[3:0] == 4'hF, i_state.f[FLAG_C], 4'h0};
        f_cp      = {i_item.imm_low == i_state.a, 1'b1,
                     i_item.imm_low[3:0] > i_state.a[3:0],
                     i_item.imm_low > i_state.a, 4'h0};
        jr_taken  = (i_item.mode == OP_JR_NZ) ? !i_state.f[FLAG_Z] : i_state.f[FLAG_C];
        jr_target = pc_p2 + {{8{i_item.imm_low[7]}}, i_item.imm_low};
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.machine_cycles = 3'd1;
        case (i_item.mode)
            OP_NOP, OP_DI: begin
                o_state.pc = pc_p1;
            end
            OP_DEC_B: begin
                o_state.b  = dec_b;
                o_state.f  = f_dec_b;
                o_state.pc = pc_p1;
            end
            OP_DEC_C: begin
                o_state.c  = dec_c;
                o_state.f  = f_dec_c;
                o_state.pc = pc_p1;
            end
            OP_LD_B, OP_LD_C, OP_LD_D, OP_LD_E, OP_LD_H, OP_LD_L, OP_LD_A: begin
                case (i_item.mode)
                    OP_LD_B: o_state.b = i_item.imm_low;
                    OP_LD_C: o_state.c = i_item.imm_low;
                    OP_LD_D: o_state.d = i_item.imm_low;
                    OP_LD_E: o_state.e = i_item.imm_low;
                    OP_LD_H: o_state.h = i_item.imm_low;
                    OP_LD_L: o_state.l = i_item.imm_low;
                    default: o_state.a = i_item.imm_low;
                endcase
                o_state.pc = pc_p2;
                o_result.machine_cycles = 3'd2;
            end
            OP_JR_NZ, OP_JR_C: begin
                o_state.pc = jr_taken ? jr_target : pc_p2;
                o_result.machine_cycles = jr_taken ? 3'd3 : 3'd2;
            end
            OP_LD_HL16: begin
                o_state.h  = i_item.imm_high;
                o_state.l  = i_item.imm_low;
                o_state.pc = pc_p3;
                o_result.machine_cycles = 3'd3;
            end
            OP_LD_HLI, OP_LD_HLD: begin
                {o_state.h, o_state.l} = (i_item.mode == OP_LD_HLI) ? hl + 16'd1 : hl - 16'd1;
                o_state.pc = pc_p1;
                o_result.mem_write   = 1'b1;
                o_result.mem_address = hl;
                o_result.write_data  = i_state.a;
                o_result.machine_cycles = 3'd2;
            end
            OP_XOR_A: begin
                o_state.a  = 8'h00;
                o_state.f  = 8'h80;
                o_state.pc = pc_p1;
            end
            OP_JP: begin
                o_state.pc = {i_item.imm_high, i_item.imm_low};
                o_result.machine_cycles = 3'd4;
            end
            OP_LDH_ST: begin
                o_state.pc = pc_p2;
                o_result.mem_write   = 1'b1;
                o_result.mem_address = {HIGH_PAGE, i_item.imm_low};
                o_result.write_data  = i_state.a;
                o_result.machine_cycles = 3'd3;
            end
            OP_LDH_LD: begin
                o_state.a  = i_item.read_data;
                o_state.pc = pc_p2;
                o_result.mem_read    = 1'b1;
                o_result.mem_address = {HIGH_PAGE, i_item.imm_low};
                o_result.machine_cycles = 3'd3;
            end
            OP_CP: begin
                o_state.f  = f_cp;
                o_state.pc = pc_p2;
                o_result.machine_cycles = 3'd2;
            end
            default: begin
                o_result.unimplemented = 1'b1;
            end
        endcase
        o_result.next_pc = o_state.pc;
    end

endmodule

`default_nettype wire

// ===== design/partial_8bit_cpu_execute.sv =====
// a request is held in the request register, then its result in the result register
// throughput: one instruction per cycle while results are taken, request and result registers run back to back
// the request register takes one new request while an earlier result waits to be taken
// reset: synchronous active low, clears A F B C D E H L, the pc and both valid flags
// depends on pce_pkg, pce_if and pce_exec
`default_nettype none

module partial_8bit_cpu_execute
    import pce_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    pce_req_if.sink   i_req,
    pce_res_if.source o_res
);

    logic    r_in_valid;
    t_item   r_item;
    t_state  r_state;
    logic    r_out_valid;
    t_result r_res;

    t_state  n_state;
    t_result n_res;
    logic    advance;

    pce_exec u_exec (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= '{mode: i_req.mode, imm_low: i_req.imm_low,
                        imm_high: i_req.imm_high, read_data: i_req.read_data};
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.mem_write      = r_res.mem_write;
    assign o_res.mem_read       = r_res.mem_read;
    assign o_res.mem_address    = r_res.mem_address;
    assign o_res.write_data     = r_res.write_data;
    assign o_res.next_pc        = r_res.next_pc;
    assign o_res.machine_cycles = r_res.machine_cycles;
    assign o_res.unimplemented  = r_res.unimplemented;

`ifndef SYNTHESIS
    a_unimpl_keeps_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_res.unimplemented |=> r_state.pc == $past(r_state.pc))
        else $error("pc moved on an unimplemented opcode");

    a_single_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.mem_write && r_res.mem_read))
        else $error("read and write in one instruction");

    a_result_pc_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_res.next_pc == r_state.pc)
        else $error("reported next pc differs from the pc register");

    a_flag_low_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.f[3:0] == 4'h0)
        else $error("low nibble of F set");
`endif

endmodule

`default_nettype wire
